FILE: src/lag_pkg.sv
// ----------------------------------------------------------------------------
// lag_pkg: shared types and constants for the life automaton generation block
// The package holds the grid defaults, the field widths of the channels and the
// control bundle that is passed to every row cell.
// ----------------------------------------------------------------------------
package lag_pkg;

	localparam int WIDTH_DEF  = 16;
	localparam int HEIGHT_DEF = 12;

	localparam int COORD_W   = 4;
	localparam int INDEX_W   = 4;
	localparam int ROW_OUT_W = 16;
	localparam int CMP_W     = 7;

	localparam logic KIND_SET  = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	typedef struct packed {
		logic             shift;
		logic             set;
		logic [CMP_W-1:0] set_y;
	} cell_ctrl_t;

endpackage

FILE: src/lag_in_if.sv
// ----------------------------------------------------------------------------
// lag_in_if: item channel
// Carries valid, ready and one set or step transaction.
// ----------------------------------------------------------------------------
interface lag_in_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [lag_pkg::COORD_W-1:0] cell_x;
	logic [lag_pkg::COORD_W-1:0] cell_y;

	modport source (output valid, output kind, output cell_x, output cell_y, input ready);
	modport sink (input valid, input kind, input cell_x, input cell_y, output ready);
endinterface

FILE: src/lag_out_if.sv
// ----------------------------------------------------------------------------
// lag_out_if: result channel
// Carries valid, ready and one emitted row of a new generation.
// ----------------------------------------------------------------------------
interface lag_out_if;
	logic                          valid;
	logic                          ready;
	logic [lag_pkg::INDEX_W-1:0]   row_index;
	logic [lag_pkg::ROW_OUT_W-1:0] row_cells;
	logic                          last;

	modport source (output valid, output row_index, output row_cells, output last, input ready);
	modport sink (input valid, input row_index, input row_cells, input last, output ready);
endinterface

FILE: src/lag_row_cell.sv
// ----------------------------------------------------------------------------
// lag_row_cell: one row of the grid
// Holds one row, takes the shift_in row on a shift and marks a cell alive
// on a set that addresses this row.
// ----------------------------------------------------------------------------
module lag_row_cell #(
	parameter int WIDTH = lag_pkg::WIDTH_DEF,
	parameter int INDEX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lag_pkg::cell_ctrl_t ctrl,
	input  logic [WIDTH-1:0]    set_mask,
	input  logic [WIDTH-1:0]    shift_in,
	output logic [WIDTH-1:0]    row
);

	logic [WIDTH-1:0] row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ctrl.shift) begin
			row_q <= shift_in;
		end else if (ctrl.set && ctrl.set_y == lag_pkg::CMP_W'(INDEX)) begin
			row_q <= row_q | set_mask;
		end
	end

	assign row = row_q;

endmodule

FILE: src/lag_rule.sv
// ----------------------------------------------------------------------------
// lag_rule: B3/S23 rule for one row
// Counts the eight neighbors of every column from three rows and applies the
// birth and survival rule; columns outside the row count as dead.
// ----------------------------------------------------------------------------
module lag_rule #(
	parameter int WIDTH = lag_pkg::WIDTH_DEF
) (
	input  logic [WIDTH-1:0] up,
	input  logic [WIDTH-1:0] mid,
	input  logic [WIDTH-1:0] down,
	output logic [WIDTH-1:0] next
);

	logic [WIDTH+1:0] up_e;
	logic [WIDTH+1:0] mid_e;
	logic [WIDTH+1:0] down_e;

	assign up_e   = {1'b0, up, 1'b0};
	assign mid_e  = {1'b0, mid, 1'b0};
	assign down_e = {1'b0, down, 1'b0};

	always_comb begin
		logic [3:0] n;
		for (int x = 0; x < WIDTH; x++) begin
			n = 4'(up_e[x]) + 4'(up_e[x+1]) + 4'(up_e[x+2])
				+ 4'(mid_e[x]) + 4'(mid_e[x+2])
				+ 4'(down_e[x]) + 4'(down_e[x+1]) + 4'(down_e[x+2]);
			if (mid[x]) begin
				next[x] = (n == 4'd2) || (n == 4'd3);
			end else begin
				next[x] = (n == 4'd3);
			end
		end
	end

endmodule

FILE: src/life_automaton_generation.sv
// ----------------------------------------------------------------------------
// life_automaton_generation: Game of Life grid, one row per unstalled cycle
//
//   channel  | direction | transaction
//   ---------+-----------+-------------------------------------------------
//   item     | in        | kind, cell_x, cell_y: set a cell or step once
//   result   | out       | row_index, row_cells, last: one new row
//
// A set transaction yields no result. A step starts with the accepting
// cycle, then moves through the rows: in each shift the chain of row cells
// rotates by one row while the rule unit computes the new row from the rows
// above, at and below it. Each new row is loaded into the output register
// by the same shift that moves it into the chain; a stalled output holds
// the chain and so holds the step.
// Reset clears all cells to dead. No new item is taken during a step.
// ----------------------------------------------------------------------------
module life_automaton_generation #(
	parameter int WIDTH  = lag_pkg::WIDTH_DEF,
	parameter int HEIGHT = lag_pkg::HEIGHT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lag_in_if.sink    item,
	lag_out_if.source result
);

	localparam int CW = $clog2(HEIGHT);

	logic [WIDTH-1:0]  row_w [HEIGHT];
	logic [WIDTH-1:0]  up_q;
	logic [WIDTH-1:0]  down_w;
	logic [WIDTH-1:0]  new_row_w;
	logic [WIDTH-1:0]  set_mask;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              last_row_w;
	logic              shift_w;
	logic              accept_w;
	lag_pkg::cell_ctrl_t ctrl;

	logic                          out_valid_q;
	logic [lag_pkg::INDEX_W-1:0]   out_index_q;
	logic [lag_pkg::ROW_OUT_W-1:0] out_cells_q;
	logic                          out_last_q;

	assign item.ready = !busy_q;
	assign accept_w   = item.valid && !busy_q;
	assign last_row_w = (cnt_q == CW'(HEIGHT - 1));
	assign shift_w    = busy_q && (!out_valid_q || result.ready);

	always_comb begin
		for (int j = 0; j < WIDTH; j++) begin
			set_mask[j] = ({{(lag_pkg::CMP_W - lag_pkg::COORD_W){1'b0}}, item.cell_x}
				== lag_pkg::CMP_W'(j));
		end
	end

	assign ctrl.shift = shift_w;
	assign ctrl.set   = accept_w && (item.kind == lag_pkg::KIND_SET);
	assign ctrl.set_y = {{(lag_pkg::CMP_W - lag_pkg::COORD_W){1'b0}}, item.cell_y};

	for (genvar i = 0; i < HEIGHT; i++) begin : g_row
		logic [WIDTH-1:0] shift_in;
		if (i == HEIGHT - 1) begin : g_tail
			assign shift_in = new_row_w;
		end else begin : g_body
			assign shift_in = row_w[i+1];
		end
		lag_row_cell #(
			.WIDTH (WIDTH),
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.set_mask (set_mask),
			.shift_in (shift_in),
			.row      (row_w[i])
		);
	end

	assign down_w = last_row_w ? '0 : row_w[1];

	lag_rule #(
		.WIDTH (WIDTH)
	) u_rule (
		.up   (up_q),
		.mid  (row_w[0]),
		.down (down_w),
		.next (new_row_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept_w && item.kind == lag_pkg::KIND_STEP) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (shift_w) begin
			cnt_q <= cnt_q + 1'b1;
			if (last_row_w) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_w) begin
			up_q <= '0;
		end else if (shift_w) begin
			up_q <= row_w[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (shift_w) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_w) begin
			out_index_q <= lag_pkg::INDEX_W'(cnt_q);
			out_cells_q <= lag_pkg::ROW_OUT_W'(new_row_w);
			out_last_q  <= last_row_w;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.row_index = out_index_q;
	assign result.row_cells = out_cells_q;
	assign result.last      = out_last_q;

endmodule

FILE: tb/tb_life_automaton_generation.sv
// ----------------------------------------------------------------------------
// tb_life_automaton_generation: self-checking bench for the Game of Life block
// Sends set and step transactions and keeps its own B3/S23 model of the grid.
// Every row of each new generation is checked against it. Patterns cover the
// grid edges, ignored sets, still lifes, oscillators, dense regions and
// random soups, with random gaps and stalls on both channels for part of the run.
// ----------------------------------------------------------------------------
module tb_life_automaton_generation;

	localparam int GW = lag_pkg::WIDTH_DEF;
	localparam int GH = lag_pkg::HEIGHT_DEF;

	typedef struct {
		logic [lag_pkg::INDEX_W-1:0]   row_index;
		logic [lag_pkg::ROW_OUT_W-1:0] row_cells;
		logic                          last;
	} grid_row_t;

	logic clk;
	logic arst_n;

	lag_in_if  item ();
	lag_out_if result ();

	life_automaton_generation #(
		.WIDTH  (GW),
		.HEIGHT (GH)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result)
	);

	logic [GW-1:0] grid [GH];
	logic [GW-1:0] snap [GH];
	grid_row_t     pending_rows [$];

	bit idle_on;
	int errors;
	int items_sent;
	int sets_done;
	int sets_ignored;
	int steps_done;
	int rows_checked;

	initial begin
		clk = 1'b0;
		forever begin
			#6 clk = ~clk;
		end
	end

	initial begin
		#2500000;
		$display("Timeout at %0t", $time);
		$display("life_automaton_generation test failed");
		$finish;
	end

	function automatic int snap_cell(int x, int y);
		if (x < 0 || x >= GW || y < 0 || y >= GH) begin
			return 0;
		end
		return int'(snap[y][x]);
	endfunction

	task automatic advance_generation();
		int n;
		grid_row_t r;
		for (int y = 0; y < GH; y++) begin
			snap[y] = grid[y];
		end
		for (int y = 0; y < GH; y++) begin
			for (int x = 0; x < GW; x++) begin
				n = 0;
				for (int dy = -1; dy <= 1; dy++) begin
					for (int dx = -1; dx <= 1; dx++) begin
						if (dx != 0 || dy != 0) begin
							n += snap_cell(x + dx, y + dy);
						end
					end
				end
				if (snap[y][x]) begin
					grid[y][x] = (n == 2 || n == 3);
				end else begin
					grid[y][x] = (n == 3);
				end
			end
			r.row_index = lag_pkg::INDEX_W'(y);
			r.row_cells = lag_pkg::ROW_OUT_W'(grid[y]);
			r.last      = (y == GH - 1);
			pending_rows = {pending_rows, r};
		end
		steps_done++;
	endtask

	task automatic apply_item(logic kind, int x, int y);
		if (kind == lag_pkg::KIND_STEP) begin
			advance_generation();
		end else if (x < GW && y < GH) begin
			grid[y][x] = 1'b1;
			sets_done++;
		end else begin
			sets_ignored++;
		end
	endtask

	task automatic send_item(logic kind, int x, int y);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			item.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		item.valid  <= 1'b1;
		item.kind   <= kind;
		item.cell_x <= lag_pkg::COORD_W'(x);
		item.cell_y <= lag_pkg::COORD_W'(y);
		do begin
			@(posedge clk);
		end while (item.ready !== 1'b1);
		items_sent++;
		apply_item(kind, x, y);
	endtask

	task automatic set_cell(int x, int y);
		send_item(lag_pkg::KIND_SET, x, y);
	endtask

	task automatic step_once();
		send_item(lag_pkg::KIND_STEP, $urandom_range(0, 15), $urandom_range(0, 15));
	endtask

	task automatic check_row();
		grid_row_t want;
		if (pending_rows.size() == 0) begin
			$display("%0t: unexpected row, actual index %0d cells %h last %b", $time,
				result.row_index, result.row_cells, result.last);
			errors++;
			return;
		end
		want = pending_rows.pop_front();
		rows_checked++;
		if (result.row_index !== want.row_index) begin
			$display("%0t: row_index expected %0d actual %0d", $time, want.row_index,
				result.row_index);
			errors++;
		end
		if (result.row_cells !== want.row_cells) begin
			$display("%0t: row %0d row_cells expected %h actual %h", $time,
				want.row_index, want.row_cells, result.row_cells);
			errors++;
		end
		if (result.last !== want.last) begin
			$display("%0t: row %0d last expected %b actual %b", $time, want.row_index,
				want.last, result.last);
			errors++;
		end
	endtask

	initial begin
		int stall_left;
		stall_left = 0;
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result.valid === 1'b1 && result.ready === 1'b1) begin
				check_row();
			end
			if (stall_left > 0) begin
				stall_left--;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 5);
			end
			result.ready <= arst_n && (stall_left == 0);
		end
	end

	task automatic test_empty_step();
		step_once();
	endtask

	// Corner cells, a repeated set, rows past the bottom edge, then a blinker
	// against the top right corner where the edge cuts the oscillation.
	task automatic test_edges_and_ignored();
		set_cell(15, 11);
		set_cell(15, 11);
		set_cell(0, 0);
		set_cell(0, 15);
		set_cell(15, 12);
		set_cell(7, 13);
		step_once();
		set_cell(13, 0);
		set_cell(14, 0);
		set_cell(15, 0);
		step_once();
		step_once();
	endtask

	task automatic test_still_and_blinker();
		set_cell(0, 10);
		set_cell(1, 10);
		set_cell(0, 11);
		set_cell(1, 11);
		set_cell(6, 5);
		set_cell(7, 5);
		set_cell(8, 5);
		step_once();
		step_once();
	endtask

	task automatic random_soup(int target, int max_sets);
		int n;
		while (items_sent < target) begin
			n = $urandom_range(1, max_sets);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					set_cell($urandom_range(0, 15), $urandom_range(GH, 15));
				end else begin
					set_cell($urandom_range(0, 15), $urandom_range(0, GH - 1));
				end
			end
			repeat ($urandom_range(1, 3)) step_once();
		end
	endtask

	// Three full rows in the middle: overcrowded cells must die.
	task automatic test_dense_band();
		for (int y = 4; y < 7; y++) begin
			for (int x = 0; x < GW; x++) begin
				set_cell(x, y);
			end
		end
		repeat (3) step_once();
	endtask

	initial begin
		arst_n       = 1'b0;
		item.valid   = 1'b0;
		item.kind    = lag_pkg::KIND_SET;
		item.cell_x  = '0;
		item.cell_y  = '0;
		idle_on      = 1'b0;
		errors       = 0;
		items_sent   = 0;
		sets_done    = 0;
		sets_ignored = 0;
		steps_done   = 0;
		rows_checked = 0;
		for (int y = 0; y < GH; y++) begin
			grid[y] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_step();
		idle_on = 1'b1;
		test_edges_and_ignored();
		test_still_and_blinker();
		random_soup(300, 30);
		test_dense_band();
		idle_on = 1'b0;
		random_soup(460, 30);

		item.valid <= 1'b0;
		@(posedge clk);
		while (pending_rows.size() != 0) begin
			@(posedge clk);
		end
		repeat (GH + 8) @(posedge clk);

		$display("Sent %0d transactions: %0d sets, %0d ignored sets, %0d steps.",
			items_sent, sets_done, sets_ignored, steps_done);
		$display("Checked %0d rows, %0d mismatches.", rows_checked, errors);
		if (errors == 0) begin
			$display("life_automaton_generation test passed");
		end else begin
			$display("life_automaton_generation test failed");
		end
		$finish;
	end

endmodule

FILE: files.f
src/lag_pkg.sv
src/lag_in_if.sv
src/lag_out_if.sv
src/lag_row_cell.sv
src/lag_rule.sv
src/life_automaton_generation.sv
tb/tb_life_automaton_generation.sv
